// ===== design/rotated_rect_bounding_box_macros.svh =====
// Assertion macros for the property checker of the bounding box block.
`ifndef ROTATED_RECT_BOUNDING_BOX_MACROS_SVH
`define ROTATED_RECT_BOUNDING_BOX_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RRBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RRBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rrbb_pkg.sv =====
`timescale 1ns / 1ps

package rrbb_pkg;

  // Default widths for the top-level parameters.
  localparam int COORD_WIDTH_DEFAULT    = 24;
  localparam int TRIG_FRAC_BITS_DEFAULT = 15;

  // Angle units: sixteenths of a degree.
  localparam int DEG_HALF_TURN       = 180;
  localparam int ANGLE_STEPS         = 16;
  localparam int HALF_TURN_STEPS     = DEG_HALF_TURN * ANGLE_STEPS;
  localparam int QUARTER_STEPS       = HALF_TURN_STEPS / 2;
  localparam int THREE_QUARTER_STEPS = QUARTER_STEPS * 3;
  localparam int FULL_STEPS          = HALF_TURN_STEPS * 2;
  localparam int ANGLE_WIDTH         = 13;
  localparam int QUARTER_ADDR_WIDTH  = $clog2(QUARTER_STEPS + 1);

  // Sine series constants: pi in Q30 and the number of Taylor terms.
  localparam logic [63:0] PI_Q30       = 64'd3373259426;
  localparam int          TAYLOR_TERMS = 12;

  // Width of the packed input beat, padded to whole bytes.
  function automatic int in_data_width(input int cw);
    return ((2 * cw + 2 * (cw - 1) + ANGLE_WIDTH + 7) / 8) * 8;
  endfunction

  // Width of the packed result beat, padded to whole bytes.
  function automatic int out_data_width(input int cw);
    return ((4 * (cw + 2) + 7) / 8) * 8;
  endfunction

  // Unsigned quotient by restoring shift and subtract, used only while the
  // table is built at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry k in Q1.frac_bits, from a rounded Q30 Taylor series.
  function automatic logic [63:0] trig_entry(input int unsigned k, input int frac_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] d;
    logic [63:0] res;
    x    = udiv64(64'(k) * PI_Q30 + 64'(HALF_TURN_STEPS / 2), 64'(HALF_TURN_STEPS));
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n < TAYLOR_TERMS; n++) begin
      d    = 64'(2 * n) * 64'(2 * n + 1);
      term = udiv64((term * x2 + (64'd1 << 29)) >> 30, d);
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    res = ((sum << frac_bits) + (64'd1 << 29)) >> 30;
    if (res > (64'd1 << frac_bits)) begin
      res = 64'd1 << frac_bits;
    end
    return res;
  endfunction

endpackage

// ===== design/rrbb_trig_rom.sv =====
`timescale 1ns / 1ps

module rrbb_trig_rom
  import rrbb_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [QUARTER_ADDR_WIDTH-1:0] addr_a,
  input  logic [QUARTER_ADDR_WIDTH-1:0] addr_b,
  output logic [TRIG_FRAC_BITS:0]       data_a,
  output logic [TRIG_FRAC_BITS:0]       data_b
);

  localparam int EW = TRIG_FRAC_BITS + 1;

  typedef logic [EW-1:0] rom_t [0:QUARTER_STEPS];

  // Build the quarter-wave table at elaboration.
  function automatic rom_t fill_rom();
    rom_t        t;
    logic [63:0] e;
    for (int k = 0; k <= QUARTER_STEPS; k++) begin
      e    = trig_entry(k, TRIG_FRAC_BITS);
      t[k] = e[EW-1:0];
    end
    return t;
  endfunction

  localparam rom_t ROM_DATA = fill_rom();

  // Two read ports with registered data; the enable holds data while stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a <= ROM_DATA[addr_a];
      data_b <= ROM_DATA[addr_b];
    end
  end

endmodule

// ===== design/rrbb_corners.sv =====
`timescale 1ns / 1ps

module rrbb_corners
  import rrbb_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEFAULT,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic [COORD_WIDTH-2:0]        in_width,
  input  logic [COORD_WIDTH-2:0]        in_height,
  input  logic [TRIG_FRAC_BITS:0]       in_sin_mag,
  input  logic [TRIG_FRAC_BITS:0]       in_cos_mag,
  input  logic                          in_neg_sin,
  input  logic                          in_neg_cos,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_pos_x,
  output logic signed [COORD_WIDTH-1:0] out_pos_y,
  output logic signed [COORD_WIDTH+1:0] off_x2,
  output logic signed [COORD_WIDTH+1:0] off_y2,
  output logic signed [COORD_WIDTH+1:0] off_x3,
  output logic signed [COORD_WIDTH+1:0] off_y3,
  output logic signed [COORD_WIDTH+1:0] off_x4,
  output logic signed [COORD_WIDTH+1:0] off_y4
);

  localparam int SW   = COORD_WIDTH - 1;
  localparam int TW   = TRIG_FRAC_BITS + 2;
  localparam int PW   = TRIG_FRAC_BITS + SW + 2;
  localparam int SUMW = TRIG_FRAC_BITS + SW + 3;
  localparam int OW   = COORD_WIDTH + 2;
  localparam logic signed [SUMW-1:0] ROUND_HALF =
    {{(SUMW-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

  logic                    prod_valid;
  logic                    prod_ready;
  logic signed [COORD_WIDTH-1:0] prod_pos_x;
  logic signed [COORD_WIDTH-1:0] prod_pos_y;
  logic signed [PW-1:0]    prod_cw;
  logic signed [PW-1:0]    prod_sw;
  logic signed [PW-1:0]    prod_sh;
  logic signed [PW-1:0]    prod_ch;
  logic signed [TW-1:0]    sin_val;
  logic signed [TW-1:0]    cos_val;
  logic signed [SW:0]      width_val;
  logic signed [SW:0]      height_val;
  logic [TW-1:0]           sin_ext;
  logic [TW-1:0]           cos_ext;
  logic signed [SUMW-1:0]  sum_x2;
  logic signed [SUMW-1:0]  sum_y2;
  logic signed [SUMW-1:0]  sum_x3;
  logic signed [SUMW-1:0]  sum_y3;
  logic signed [SUMW-1:0]  sum_x4;
  logic signed [SUMW-1:0]  sum_y4;

  // Stage handshake: a stage loads when it is empty or its successor loads.
  assign in_ready   = !prod_valid || prod_ready;
  assign prod_ready = !out_valid || out_ready;

  // Signed sine and cosine from the table magnitudes and quadrant signs.
  always_comb begin
    sin_ext    = {1'b0, in_sin_mag};
    cos_ext    = {1'b0, in_cos_mag};
    sin_val    = signed'(in_neg_sin ? -sin_ext : sin_ext);
    cos_val    = signed'(in_neg_cos ? -cos_ext : cos_ext);
    width_val  = signed'({1'b0, in_width});
    height_val = signed'({1'b0, in_height});
  end

  // Product stage: the four trig-by-size products.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
    if (in_ready) begin
      prod_pos_x <= in_pos_x;
      prod_pos_y <= in_pos_y;
      prod_cw    <= PW'(cos_val * width_val);
      prod_sw    <= PW'(sin_val * width_val);
      prod_sh    <= PW'(sin_val * height_val);
      prod_ch    <= PW'(cos_val * height_val);
    end
  end

  // Exact corner sums with the rounding half already added.
  always_comb begin
    sum_x2 = SUMW'(prod_cw) + ROUND_HALF;
    sum_y2 = SUMW'(prod_sw) + ROUND_HALF;
    sum_x3 = SUMW'(prod_cw) - SUMW'(prod_sh) + ROUND_HALF;
    sum_y3 = SUMW'(prod_sw) + SUMW'(prod_ch) + ROUND_HALF;
    sum_x4 = ROUND_HALF - SUMW'(prod_sh);
    sum_y4 = SUMW'(prod_ch) + ROUND_HALF;
  end

  // Offset stage: an arithmetic shift floors, so the result rounds half up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
    if (prod_ready) begin
      out_pos_x <= prod_pos_x;
      out_pos_y <= prod_pos_y;
      off_x2    <= OW'(sum_x2 >>> TRIG_FRAC_BITS);
      off_y2    <= OW'(sum_y2 >>> TRIG_FRAC_BITS);
      off_x3    <= OW'(sum_x3 >>> TRIG_FRAC_BITS);
      off_y3    <= OW'(sum_y3 >>> TRIG_FRAC_BITS);
      off_x4    <= OW'(sum_x4 >>> TRIG_FRAC_BITS);
      off_y4    <= OW'(sum_y4 >>> TRIG_FRAC_BITS);
    end
  end

endmodule

// ===== design/rrbb_extent.sv =====
`timescale 1ns / 1ps

module rrbb_extent
  import rrbb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH+1:0] off_x2,
  input  logic signed [COORD_WIDTH+1:0] off_y2,
  input  logic signed [COORD_WIDTH+1:0] off_x3,
  input  logic signed [COORD_WIDTH+1:0] off_y3,
  input  logic signed [COORD_WIDTH+1:0] off_x4,
  input  logic signed [COORD_WIDTH+1:0] off_y4,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH+1:0] min_x,
  output logic signed [COORD_WIDTH+1:0] min_y,
  output logic signed [COORD_WIDTH+1:0] max_x,
  output logic signed [COORD_WIDTH+1:0] max_y
);

  localparam int OW = COORD_WIDTH + 2;

  logic                          ext_valid;
  logic                          ext_ready;
  logic signed [COORD_WIDTH-1:0] ext_pos_x;
  logic signed [COORD_WIDTH-1:0] ext_pos_y;
  logic signed [OW-1:0]          ext_min_x;
  logic signed [OW-1:0]          ext_min_y;
  logic signed [OW-1:0]          ext_max_x;
  logic signed [OW-1:0]          ext_max_y;
  logic signed [OW-1:0]          lo_xa, lo_xb, hi_xa, hi_xb;
  logic signed [OW-1:0]          lo_ya, lo_yb, hi_ya, hi_yb;
  logic signed [OW-1:0]          min_x_next, min_y_next, max_x_next, max_y_next;

  assign in_ready  = !ext_valid || ext_ready;
  assign ext_ready = !out_valid || out_ready;

  // Extremes of the offsets; the anchor corner has offset zero.
  always_comb begin
    lo_xa      = off_x2[OW-1] ? off_x2 : '0;
    hi_xa      = off_x2[OW-1] ? '0 : off_x2;
    lo_xb      = (off_x3 < off_x4) ? off_x3 : off_x4;
    hi_xb      = (off_x3 > off_x4) ? off_x3 : off_x4;
    lo_ya      = off_y2[OW-1] ? off_y2 : '0;
    hi_ya      = off_y2[OW-1] ? '0 : off_y2;
    lo_yb      = (off_y3 < off_y4) ? off_y3 : off_y4;
    hi_yb      = (off_y3 > off_y4) ? off_y3 : off_y4;
    min_x_next = (lo_xa < lo_xb) ? lo_xa : lo_xb;
    max_x_next = (hi_xa > hi_xb) ? hi_xa : hi_xb;
    min_y_next = (lo_ya < lo_yb) ? lo_ya : lo_yb;
    max_y_next = (hi_ya > hi_yb) ? hi_ya : hi_yb;
  end

  // Extent stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_valid <= 1'b0;
    end else if (in_ready) begin
      ext_valid <= in_valid;
    end
    if (in_ready) begin
      ext_pos_x <= in_pos_x;
      ext_pos_y <= in_pos_y;
      ext_min_x <= min_x_next;
      ext_min_y <= min_y_next;
      ext_max_x <= max_x_next;
      ext_max_y <= max_y_next;
    end
  end

  // Result register: move the extremes back to the anchor.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ext_ready) begin
      out_valid <= ext_valid;
    end
    if (ext_ready) begin
      min_x <= OW'(ext_pos_x) + ext_min_x;
      min_y <= OW'(ext_pos_y) + ext_min_y;
      max_x <= OW'(ext_pos_x) + ext_max_x;
      max_y <= OW'(ext_pos_y) + ext_max_y;
    end
  end

endmodule

// ===== design/rotated_rect_bounding_box.sv =====
`timescale 1ns / 1ps

// Axis-aligned bounding box of a rectangle rotated about its anchor corner.
// Input channel s_*: one beat carries anchor x/y (signed Q16.8), width and
// height (unsigned Q15.8) and the angle in sixteenths of a degree. Output
// channel m_*: one beat per input beat, min/max x and y as signed Q18.8.
// From input acceptance to m_tvalid a beat passes six registers in line:
// input register, registered sine/cosine table read, products,
// rounded corner offsets, extremes, and the result register that adds the
// anchor back. Throughput is one rectangle per cycle while the receiver
// accepts; the 1441-entry quarter-wave ROM is read on two ports (sine, cosine).
// Every stage has its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled receiver first fills the bubbles and only
// then holds s_tready low. Results are never dropped or repeated.
// Reset (rst, synchronous) clears all valid bits; the block holds no other
// state and needs no initialization pass.
module rotated_rect_bounding_box
  import rrbb_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEFAULT,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // pos_x, pos_y, rect_width, rect_height, angle (lowest bit first)
  input  logic [in_data_width(COORD_WIDTH)-1:0]  s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // min_x, min_y, max_x, max_y (lowest bit first)
  output logic [out_data_width(COORD_WIDTH)-1:0] m_tdata
);

  localparam int SW     = COORD_WIDTH - 1;
  localparam int OW     = COORD_WIDTH + 2;
  localparam int EW     = TRIG_FRAC_BITS + 1;
  localparam int AW     = ANGLE_WIDTH;
  localparam int QW     = QUARTER_ADDR_WIDTH;
  localparam int PY_LSB = COORD_WIDTH;
  localparam int W_LSB  = 2 * COORD_WIDTH;
  localparam int H_LSB  = 2 * COORD_WIDTH + SW;
  localparam int A_LSB  = 2 * COORD_WIDTH + 2 * SW;
  localparam int OUT_DW = out_data_width(COORD_WIDTH);

  // Input register.
  logic                          in_valid;
  logic                          in_ready;
  logic signed [COORD_WIDTH-1:0] in_pos_x;
  logic signed [COORD_WIDTH-1:0] in_pos_y;
  logic [SW-1:0]                 in_width;
  logic [SW-1:0]                 in_height;
  logic [AW-1:0]                 in_angle;

  // Table stage.
  logic                          trig_valid;
  logic                          trig_ready;
  logic signed [COORD_WIDTH-1:0] trig_pos_x;
  logic signed [COORD_WIDTH-1:0] trig_pos_y;
  logic [SW-1:0]                 trig_width;
  logic [SW-1:0]                 trig_height;
  logic                          trig_neg_sin;
  logic                          trig_neg_cos;
  logic [EW-1:0]                 sin_mag;
  logic [EW-1:0]                 cos_mag;

  // Angle decode.
  logic [AW-1:0] angle_wrap;
  logic [AW-1:0] quad_base;
  logic [AW-1:0] angle_rem;
  logic [QW-1:0] rem_q;
  logic [QW-1:0] rem_mirror;
  logic          mirror;
  logic          neg_sin;
  logic          neg_cos;
  logic [QW-1:0] addr_sin;
  logic [QW-1:0] addr_cos;

  // Corner and extent stages.
  logic                          corner_ready_in;
  logic                          corner_valid;
  logic                          corner_ready;
  logic signed [COORD_WIDTH-1:0] corner_pos_x;
  logic signed [COORD_WIDTH-1:0] corner_pos_y;
  logic signed [OW-1:0]          off_x2, off_y2, off_x3, off_y3, off_x4, off_y4;
  logic signed [OW-1:0]          min_x, min_y, max_x, max_y;

  assign s_tready   = in_ready;
  assign in_ready   = !in_valid || trig_ready;
  assign trig_ready = !trig_valid || corner_ready_in;

  // Input register: unpack the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_tvalid;
    end
    if (in_ready) begin
      in_pos_x  <= signed'(s_tdata[COORD_WIDTH-1:0]);
      in_pos_y  <= signed'(s_tdata[PY_LSB +: COORD_WIDTH]);
      in_width  <= s_tdata[W_LSB +: SW];
      in_height <= s_tdata[H_LSB +: SW];
      in_angle  <= s_tdata[A_LSB +: AW];
    end
  end

  // Quadrant decode: wrap the angle, then pick table index and signs.
  always_comb begin
    angle_wrap = (in_angle >= AW'(FULL_STEPS)) ? in_angle - AW'(FULL_STEPS) : in_angle;
    if (angle_wrap < AW'(QUARTER_STEPS)) begin
      quad_base = '0;
    end else if (angle_wrap < AW'(HALF_TURN_STEPS)) begin
      quad_base = AW'(QUARTER_STEPS);
    end else if (angle_wrap < AW'(THREE_QUARTER_STEPS)) begin
      quad_base = AW'(HALF_TURN_STEPS);
    end else begin
      quad_base = AW'(THREE_QUARTER_STEPS);
    end
    mirror = (quad_base == AW'(QUARTER_STEPS)) || (quad_base == AW'(THREE_QUARTER_STEPS));
    neg_sin = (quad_base == AW'(HALF_TURN_STEPS)) ||
              (quad_base == AW'(THREE_QUARTER_STEPS));
    neg_cos = (quad_base == AW'(QUARTER_STEPS)) || (quad_base == AW'(HALF_TURN_STEPS));
    angle_rem  = angle_wrap - quad_base;
    rem_q      = angle_rem[QW-1:0];
    rem_mirror = QW'(QUARTER_STEPS) - rem_q;
    addr_sin   = mirror ? rem_mirror : rem_q;
    addr_cos   = mirror ? rem_q : rem_mirror;
  end

  rrbb_trig_rom #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rom (
    .clk    (clk),
    .rd_en  (trig_ready),
    .addr_a (addr_sin),
    .addr_b (addr_cos),
    .data_a (sin_mag),
    .data_b (cos_mag)
  );

  // Table stage: payload alongside the registered table read.
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_valid <= 1'b0;
    end else if (trig_ready) begin
      trig_valid <= in_valid;
    end
    if (trig_ready) begin
      trig_pos_x   <= in_pos_x;
      trig_pos_y   <= in_pos_y;
      trig_width   <= in_width;
      trig_height  <= in_height;
      trig_neg_sin <= neg_sin;
      trig_neg_cos <= neg_cos;
    end
  end

  rrbb_corners #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_corners (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (trig_valid),
    .in_ready   (corner_ready_in),
    .in_pos_x   (trig_pos_x),
    .in_pos_y   (trig_pos_y),
    .in_width   (trig_width),
    .in_height  (trig_height),
    .in_sin_mag (sin_mag),
    .in_cos_mag (cos_mag),
    .in_neg_sin (trig_neg_sin),
    .in_neg_cos (trig_neg_cos),
    .out_valid  (corner_valid),
    .out_ready  (corner_ready),
    .out_pos_x  (corner_pos_x),
    .out_pos_y  (corner_pos_y),
    .off_x2     (off_x2),
    .off_y2     (off_y2),
    .off_x3     (off_x3),
    .off_y3     (off_y3),
    .off_x4     (off_x4),
    .off_y4     (off_y4)
  );

  rrbb_extent #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_extent (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corner_valid),
    .in_ready  (corner_ready),
    .in_pos_x  (corner_pos_x),
    .in_pos_y  (corner_pos_y),
    .off_x2    (off_x2),
    .off_y2    (off_y2),
    .off_x3    (off_x3),
    .off_y3    (off_y3),
    .off_x4    (off_x4),
    .off_y4    (off_y4),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .min_x     (min_x),
    .min_y     (min_y),
    .max_x     (max_x),
    .max_y     (max_y)
  );

  // Pack the result beat, zero padded to whole bytes.
  assign m_tdata = OUT_DW'({max_y, max_x, min_y, min_x});

endmodule

// ===== design/rrbb_checker.sv =====
`timescale 1ns / 1ps
`include "rotated_rect_bounding_box_macros.svh"

module rrbb_props
  import rrbb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   s_tready,
  input logic                                   m_tvalid,
  input logic                                   m_tready,
  input logic [out_data_width(COORD_WIDTH)-1:0] m_tdata
);

  localparam int OW = COORD_WIDTH + 2;

  logic                 out_stall;
  logic signed [OW-1:0] box_min_x;
  logic signed [OW-1:0] box_min_y;
  logic signed [OW-1:0] box_max_x;
  logic signed [OW-1:0] box_max_y;
  logic                 box_ordered;

  // Fields of the result beat and the ordering of the box.
  assign out_stall   = m_tvalid && !m_tready;
  assign box_min_x   = m_tdata[OW-1:0];
  assign box_min_y   = m_tdata[2*OW-1:OW];
  assign box_max_x   = m_tdata[3*OW-1:2*OW];
  assign box_max_y   = m_tdata[4*OW-1:3*OW];
  assign box_ordered = (box_min_x <= box_max_x) && (box_min_y <= box_max_y);

  // A stalled result beat stays offered and unchanged.
  `RRBB_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_tvalid, "result beat dropped")
  `RRBB_ASSERT_NEXT(a_out_stable, clk, rst, out_stall, $stable(m_tdata), "result beat changed")

  // Nothing comes out in the first cycle after reset.
  `RRBB_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_tvalid, "result beat after reset")

  // With the receiver ready, every stage moves, so the input side is ready too.
  `RRBB_ASSERT_NOW(a_ready_flow, clk, rst, m_tready, s_tready, "input stalled while draining")

  // The box is never inverted.
  `RRBB_ASSERT_NOW(a_box_order, clk, rst, m_tvalid, box_ordered, "box minimum exceeds maximum")

endmodule

bind rotated_rect_bounding_box rrbb_props #(
  .COORD_WIDTH (COORD_WIDTH)
) u_rrbb_props (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/rrbb_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the bounding box block, works out the box for
// every accepted rectangle and compares each result beat against it in order.
module rrbb_checker #(
  parameter int IN_W  = 112,
  parameter int OUT_W = 104
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  // pos_x, pos_y, rect_width, rect_height, angle (lowest bit first)
  input  logic [IN_W-1:0]    s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  // min_x, min_y, max_x, max_y (lowest bit first)
  input  logic [OUT_W-1:0]   m_tdata,
  output int unsigned        pending,
  output int unsigned        mismatches,
  output int unsigned        boxes_checked
);

  localparam int          FRAC          = 15;
  localparam int unsigned QUARTER       = 1440;
  localparam int unsigned HALF_TURN     = 2 * QUARTER;
  localparam int unsigned FULL_TURN     = 4 * QUARTER;
  localparam longint unsigned PI_FIX30  = 64'd3373259426;
  localparam int          SERIES_LEN    = 12;

  typedef struct packed {
    logic [12:0] angle;
    logic [22:0] rect_height;
    logic [22:0] rect_width;
    logic [23:0] pos_y;
    logic [23:0] pos_x;
  } rect_t;

  typedef struct packed {
    logic [25:0] max_y;
    logic [25:0] max_x;
    logic [25:0] min_y;
    logic [25:0] min_x;
  } box_t;

  longint unsigned quarter_sine [0:QUARTER];
  box_t            box_queue [$];
  int unsigned     fail_cnt = 0;
  int unsigned     check_cnt = 0;

  // Sine of k steps of pi/2880 in Q1.15, from a rounded Taylor series in Q30.
  function automatic longint unsigned series_sine(int unsigned k);
    longint unsigned arg;
    longint unsigned arg_sq;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned div;
    longint unsigned scaled;
    arg    = (64'(k) * PI_FIX30 + 64'(HALF_TURN / 2)) / 64'(HALF_TURN);
    arg_sq = (arg * arg + (64'd1 << 29)) >> 30;
    term   = arg;
    acc    = arg;
    for (int n = 1; n < SERIES_LEN; n++) begin
      div  = 64'(2 * n) * 64'(2 * n + 1);
      term = ((term * arg_sq + (64'd1 << 29)) >> 30) / div;
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    scaled = ((acc << FRAC) + (64'd1 << 29)) >> 30;
    if (scaled > (64'd1 << FRAC)) begin
      scaled = 64'd1 << FRAC;
    end
    return scaled;
  endfunction

  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_sine[k] = series_sine(k);
    end
  end

  // Odd quadrants mirror the table, the lower half-turn negates it.
  function automatic longint sine_at(int unsigned a);
    logic [1:0]  quad;
    int unsigned rem;
    longint      mag;
    quad = 2'((a / QUARTER) % 4);
    rem  = a % QUARTER;
    mag  = longint'(quarter_sine[quad[0] ? QUARTER - rem : rem]);
    return quad[1] ? -mag : mag;
  endfunction

  // Q.23 product rounded half up to Q.8, that is floor(v / 2^15 + 1/2).
  function automatic longint round_to_q8(longint v);
    return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint lesser(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint greater(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // Corners are the anchor plus rotated (0,0), (w,0), (w,h) and (0,h).
  function automatic box_t bound_rotated(rect_t r);
    longint      px;
    longint      py;
    longint      w;
    longint      h;
    longint      sn;
    longint      cs;
    longint      x2, y2, x3, y3, x4, y4;
    int unsigned a;
    box_t        b;
    px = longint'($signed(r.pos_x));
    py = longint'($signed(r.pos_y));
    w  = longint'(r.rect_width);
    h  = longint'(r.rect_height);
    a  = int'(r.angle);
    if (a >= FULL_TURN) begin
      a = a - FULL_TURN;
    end
    sn = sine_at(a);
    cs = sine_at((a + QUARTER) % FULL_TURN);
    x2 = px + round_to_q8(cs * w);
    y2 = py + round_to_q8(sn * w);
    x3 = px + round_to_q8(cs * w - sn * h);
    y3 = py + round_to_q8(sn * w + cs * h);
    x4 = px + round_to_q8(-(sn * h));
    y4 = py + round_to_q8(cs * h);
    b.min_x = 26'(lesser(lesser(px, x2), lesser(x3, x4)));
    b.min_y = 26'(lesser(lesser(py, y2), lesser(y3, y4)));
    b.max_x = 26'(greater(greater(px, x2), greater(x3, x4)));
    b.max_y = 26'(greater(greater(py, y2), greater(y3, y4)));
    return b;
  endfunction

  function automatic int unsigned compare_field(string name, logic [25:0] want,
                                                logic [25:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
      return 1;
    end
    return 0;
  endfunction

  // Result beats are retired before the new rectangle is queued, so a beat
  // can never be matched against a rectangle accepted on the same edge.
  always @(posedge clk) begin
    box_t        got;
    box_t        want;
    int unsigned bad;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = box_t'(m_tdata[$bits(box_t)-1:0]);
        if (box_queue.size() == 0) begin
          $display("%0t ns: result beat with no rectangle outstanding, expected none, actual %h",
                   $time, got);
          fail_cnt++;
        end else begin
          want = box_queue.pop_front();
          bad  = compare_field("min_x", want.min_x, got.min_x)
               + compare_field("min_y", want.min_y, got.min_y)
               + compare_field("max_x", want.max_x, got.max_x)
               + compare_field("max_y", want.max_y, got.max_y);
          if (bad != 0) begin
            fail_cnt++;
          end
          check_cnt++;
        end
      end
      if (s_tvalid && s_tready) begin
        box_queue.push_back(bound_rotated(rect_t'(s_tdata[$bits(rect_t)-1:0])));
      end
    end
    pending       <= box_queue.size();
    mismatches    <= fail_cnt;
    boxes_checked <= check_cnt;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Drives rectangles into the bounding box block and gives the verdict; the
// checker beside the block does all prediction and comparison.
module tb;
  import rrbb_pkg::*;

  localparam int CW             = COORD_WIDTH_DEFAULT;
  localparam int IN_W           = in_data_width(CW);
  localparam int OUT_W          = out_data_width(CW);
  localparam int IDLE_PERCENT   = 6;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int RANDOM_RECTS   = 1880;
  localparam int DRAIN_CYCLES   = 12;
  localparam int TIMEOUT_NS     = 2_400_000;

  localparam logic [23:0] POS_MAX  = 24'h7FFFFF;
  localparam logic [23:0] POS_MIN  = 24'h800000;
  localparam logic [22:0] SIZE_MAX = 23'h7FFFFF;
  localparam logic [22:0] ONE_Q8   = 23'd256;
  localparam logic [12:0] ANGLE_MAX = 13'h1FFF;

  logic             clk;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  logic             steady        = 1'b0;
  int unsigned      hold_requests = 0;
  int unsigned      rects_sent    = 0;
  int unsigned      directed_sent = 0;
  int unsigned      pending;
  int unsigned      mismatches;
  int unsigned      boxes_checked;

  rotated_rect_bounding_box i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rrbb_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .pending       (pending),
    .mismatches    (mismatches),
    .boxes_checked (boxes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one rectangle, with an occasional idle gap ahead of it, and hold
  // it until the block takes the beat.
  task automatic send_rect(input logic [23:0] px, input logic [23:0] py,
                           input logic [22:0] w, input logic [22:0] h,
                           input logic [12:0] ang);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({ang, h, w, py, px});
    do @(posedge clk); while (!s_tready);
    rects_sent++;
  endtask

  // Stop offering and wait until every box has come back.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_rect();
    logic [23:0] px;
    logic [23:0] py;
    logic [22:0] w;
    logic [22:0] h;
    logic [12:0] ang;
    int unsigned pick;
    px = 24'($urandom);
    py = 24'($urandom);
    if ($urandom_range(99) < 4) begin
      px = $urandom_range(1) ? POS_MAX : POS_MIN;
      py = $urandom_range(1) ? POS_MAX : POS_MIN;
    end
    // Mostly sprite-sized rectangles, many full-range ones, some degenerate.
    pick = $urandom_range(99);
    if (pick < 50) begin
      w = 23'($urandom_range(4095));
      h = 23'($urandom_range(4095));
    end else if (pick < 85) begin
      w = 23'($urandom);
      h = 23'($urandom);
    end else if (pick < 93) begin
      w = $urandom_range(1) ? 23'($urandom) : '0;
      h = (w == '0) ? 23'($urandom) : '0;
    end else begin
      w = $urandom_range(1) ? SIZE_MAX : 23'($urandom_range(3));
      h = $urandom_range(1) ? SIZE_MAX : 23'($urandom_range(3));
    end
    // Angles: mostly anywhere in the turn, some on 15 degree marks, and a
    // few beyond a full turn that the block has to wrap.
    pick = $urandom_range(99);
    if (pick < 4) begin
      ang = 13'($urandom_range(ANGLE_MAX, FULL_STEPS));
    end else if (pick < 14) begin
      ang = 13'($urandom_range(23) * (QUARTER_STEPS / 6));
    end else begin
      ang = 13'($urandom_range(FULL_STEPS - 1));
    end
    send_rect(px, py, w, h, ang);
  endtask

  // The receiver stalls at random, except in the steady stretch, and takes
  // one long hold-off whenever the stimulus asks for it.
  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      if (holds_done != hold_requests) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of position and size on every quadrant boundary.
    send_rect('0, '0, '0, '0, '0);
    send_rect(POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX, '0);
    send_rect(POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX, 13'(HALF_TURN_STEPS));
    send_rect(POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX, 13'(QUARTER_STEPS));
    send_rect(POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX, 13'(THREE_QUARTER_STEPS));
    send_rect(POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX, 13'(FULL_STEPS - 1));
    send_rect(POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX, 13'd1);
    send_rect('0, '0, SIZE_MAX, '0, 13'(QUARTER_STEPS - 1));
    send_rect('0, '0, '0, SIZE_MAX, 13'(QUARTER_STEPS + 1));
    send_rect('0, '0, ONE_Q8, ONE_Q8, 13'(QUARTER_STEPS / 2));
    send_rect(24'h000100, 24'hFFFF00, 23'd5000, '0, 13'(QUARTER_STEPS / 3));
    send_rect(24'hFFF000, 24'h001000, '0, 23'd7000, 13'd2400);
    // Angles at and past a full turn wrap back into range; the last needs no wrap.
    send_rect(24'h012345, 24'hFEDCBA, 23'd3000, 23'd2000, 13'(FULL_STEPS));
    send_rect(24'h012345, 24'hFEDCBA, 23'd3000, 23'd2000, ANGLE_MAX);
    send_rect('0, '0, 23'd4321, 23'd1234, 13'h1000);
    // Unit-step sizes where rounding of negative offsets decides the result.
    send_rect('0, '0, 23'd1, 23'd1, 13'd4000);
    send_rect(24'hFFFFFF, 24'hFFFFFF, 23'd3, 23'd5, 13'(HALF_TURN_STEPS + 7));
    send_rect('0, '0, 23'd1, 23'd1, 13'(THREE_QUARTER_STEPS + 3));
    send_rect(POS_MAX, POS_MIN, 23'h555555, 23'h2AAAAA, 13'h0AAA);
    send_rect(POS_MIN, POS_MAX, 23'h2AAAAA, 23'h555555, 13'h1555);
    directed_sent = rects_sent;

    for (int i = 0; i < RANDOM_RECTS; i++) begin
      if (i == 600) begin
        steady <= 1'b1;
      end
      if (i == 1000) begin
        // Keep offering back to back while the receiver holds off, so the
        // pipeline fills and the block stalls its input.
        hold_requests <= hold_requests + 1;
      end
      if (i == 1150) begin
        steady <= 1'b0;
      end
      if (i == 1300) begin
        wait_for_drain();
      end
      send_random_rect();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d rectangles (%0d directed), %0d boxes compared, one %0d-cycle",
             rects_sent, directed_sent, boxes_checked, RX_HOLD_CYCLES);
    $display("receiver hold-off with back-to-back input and one full drain pause.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d boxes still outstanding.", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== rotated_rect_bounding_box.f =====
+incdir+design
design/rrbb_pkg.sv
design/rrbb_trig_rom.sv
design/rrbb_corners.sv
design/rrbb_extent.sv
design/rotated_rect_bounding_box.sv
design/rrbb_checker.sv
verif/rrbb_checker.sv
verif/tb.sv
